[rtl/jac_pkg.sv]
package jac_pkg;

	// register field widths
	localparam int CENTER_W = 12;
	localparam int DZ_W     = 11;
	localparam int LIM_W    = 15;
	localparam int NCAL_W   = 10;
	localparam int CFG_W    = 15;
	localparam int CFG_AW   = 2;

	// internal state widths
	localparam int BIAS_W   = 13;
	localparam int SUM_W    = 22;
	localparam int AXIS_W   = 16;

	// shared divider: quotient shift register, divisor and step counter
	localparam int QUO_W       = SUM_W;
	localparam int DIV_W       = 12;
	localparam int STEPS_W     = 5;
	localparam int SCALE_SHIFT = 16;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int SAMPLE_BITS_DEF  = 12;

	localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(2048);
	localparam logic [DZ_W-1:0]     DZ_RST     = DZ_W'(100);
	localparam logic [LIM_W-1:0]    LIM_RST    = LIM_W'(32767);
	localparam logic [NCAL_W-1:0]   NCAL_RST   = NCAL_W'(20);

	localparam logic [CFG_AW-1:0] REG_CENTER   = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] REG_DEADZONE = CFG_AW'(1);
	localparam logic [CFG_AW-1:0] REG_LIMIT    = CFG_AW'(2);
	localparam logic [CFG_AW-1:0] REG_NCAL     = CFG_AW'(3);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_CAL_DIV,
		ST_CENTER,
		ST_SHIFT,
		ST_MUL,
		ST_SCL_GO,
		ST_SCL_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                start;
		logic [STEPS_W-1:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

[rtl/jac_div.sv]
module jac_div #(
	parameter int RW = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  jac_pkg::div_req_t          req,
	input  logic [RW-1:0]              rem_init,
	input  logic [jac_pkg::QUO_W-1:0]  num_init,
	input  logic [jac_pkg::DIV_W-1:0]  divisor,
	output jac_pkg::div_stat_t         stat,
	output logic [jac_pkg::QUO_W-1:0]  quotient
);
	import jac_pkg::*;

	logic               run_q;
	logic               ovf_q;
	logic [STEPS_W-1:0] cnt_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dvs_q;
	logic [QUO_W-1:0]   num_q;

	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           fits;
	logic           ovf_in;

	// quotient would not fit in the requested number of steps
	assign ovf_in = rem_init >= {{(RW-DIV_W){1'b0}}, divisor};

	assign trial = {rem_q, num_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			ovf_q <= ovf_in;
			cnt_q <= ovf_in ? '0 : req.steps;
		end else if (run_q) begin
			if (cnt_q == '0) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - STEPS_W'(1);
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= divisor;
			num_q <= num_init;
			rem_q <= rem_init[DIV_W-1:0];
		end else if (run_q && cnt_q != '0) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			num_q <= {num_q[QUO_W-2:0], fits};
		end
	end

	always_comb begin
		stat.done = run_q && (cnt_q == '0);
		stat.ovf  = ovf_q;
	end

	assign quotient = num_q;

endmodule

[rtl/joystick_axis_conditioner.sv]
// Joystick axis conditioner. One beat on the s_ side carries one scan of NUM_CHANNELS ADC
// samples; one beat on the m_ side returns the conditioned signed positions. Each channel
// has the centre level and its stored bias removed, reads zero inside the deadzone, and is
// otherwise scaled by output_limit / (center_level - 1 - deadzone_width) and saturated.
// A scan with s_tuser set is a calibration scan: its samples add into per-channel sums,
// and the calib_samples-th such scan turns the averages into new biases (m_tuser set).
// Items are handled one at a time by a small sequencer around one shared bit-serial
// divider: each channel passes through centre, deadzone and multiply steps, then waits on
// the divider, which stops early when the result saturates. A calibration scan adds a
// calibration step for each channel, and a completing one also runs the 22-step average
// division for each channel. The finished result sits in an output register, so the next
// scan can be taken while it waits.
module joystick_axis_conditioner #(
	parameter int NUM_CHANNELS = jac_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = jac_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	// fields from bit 0: left_x_sample, left_y_sample, right_x_sample, right_y_sample
	input  logic [((NUM_CHANNELS*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	// command
	input  logic                                             s_tuser,
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	// fields from bit 0: left_x_axis, left_y_axis, right_x_axis, right_y_axis
	output logic [((NUM_CHANNELS*jac_pkg::AXIS_W+7)/8)*8-1:0] m_tdata,
	// calibration_done
	output logic                                             m_tuser,
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	input  logic                                             cfg_we,
	input  logic [jac_pkg::CFG_AW-1:0]                       cfg_addr,
	input  logic [jac_pkg::CFG_W-1:0]                        cfg_wdata
);
	import jac_pkg::*;

	localparam int S_TDATA_W = ((NUM_CHANNELS*SAMPLE_BITS+7)/8)*8;
	localparam int M_TDATA_W = ((NUM_CHANNELS*AXIS_W+7)/8)*8;
	localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	// centred value, its magnitude, and the scaled product
	localparam int XW = ((SAMPLE_BITS > BIAS_W) ? SAMPLE_BITS : BIAS_W) + 2;
	localparam int MW = XW - 1;
	localparam int PW = MW + LIM_W;
	localparam int RW = PW - SCALE_SHIFT;

	state_t state_q, state_d;

	// configuration
	logic [CENTER_W-1:0] center_q;
	logic [DZ_W-1:0]     dz_q;
	logic [LIM_W-1:0]    lim_q;
	logic [NCAL_W-1:0]   ncal_q;

	// calibration state
	logic [BIAS_W-1:0]   bias_q [NUM_CHANNELS];
	logic [SUM_W-1:0]    sum_q  [NUM_CHANNELS];
	logic [NCAL_W-1:0]   count_q;

	// per-item working registers
	logic [CW-1:0]          ch_q;
	logic                   cmd_q;
	logic                   done_q;
	logic [SAMPLE_BITS-1:0] samp_q [NUM_CHANNELS];
	logic [DIV_W-1:0]       den_q;
	logic [DIV_W-1:0]       n_q;
	logic [XW-1:0]          x_q;
	logic [MW-1:0]          m_q;
	logic                   neg_q;
	logic [PW-1:0]          prod_q;
	logic [AXIS_W-1:0]      res_q [NUM_CHANNELS];

	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;
	logic                 m_tvalid_q;

	// control
	logic       accept;
	logic       last_ch;
	logic       sel_cal;
	logic       out_load;
	div_req_t   div_req;
	div_stat_t  div_stat;
	logic [RW-1:0]    div_rem;
	logic [QUO_W-1:0] div_num;
	logic [DIV_W-1:0] div_dvs;
	logic [QUO_W-1:0] div_quo;

	// combinational datapath
	logic [NCAL_W-1:0] ncal_eff;
	logic [NCAL_W-1:0] cnt_next;
	logic              complete;
	logic [BIAS_W-1:0] den_full;
	logic [SUM_W-1:0]  new_sum;
	logic [XW-1:0]     x_c;
	logic [XW-1:0]     mag_c;
	logic [MW-1:0]     dz_ext;
	logic [PW-1:0]     prod_c;
	logic [AXIS_W-1:0] lim16;
	logic [AXIS_W-1:0] q16;
	logic [AXIS_W-1:0] magr;
	logic [AXIS_W-1:0] res_c;
	logic [BIAS_W-1:0] bias_c;

	assign accept  = s_tvalid && s_tready;
	assign last_ch = ch_q == CW'(NUM_CHANNELS - 1);

	assign ncal_eff = (ncal_q == '0) ? NCAL_W'(1) : ncal_q;
	assign cnt_next = count_q + NCAL_W'(1);
	// counter wrapping to zero also completes
	assign complete = (cnt_next >= ncal_eff) || (cnt_next == '0);
	assign den_full = {1'b0, center_q} - BIAS_W'(1) - {2'b0, dz_q};

	assign new_sum = sum_q[ch_q] + {{(SUM_W-SAMPLE_BITS){1'b0}}, samp_q[ch_q]};

	assign x_c = {{(XW-SAMPLE_BITS){1'b0}}, samp_q[ch_q]}
		- {{(XW-CENTER_W){1'b0}}, center_q}
		- {{(XW-BIAS_W){bias_q[ch_q][BIAS_W-1]}}, bias_q[ch_q]};
	assign mag_c  = x_q[XW-1] ? (~x_q + XW'(1)) : x_q;
	assign dz_ext = {{(MW-DZ_W){1'b0}}, dz_q};
	assign prod_c = m_q * lim_q;

	assign lim16  = {1'b0, lim_q};
	assign q16    = div_quo[AXIS_W-1:0];
	assign magr   = (div_stat.ovf || q16 > lim16) ? lim16 : q16;
	assign res_c  = neg_q ? (~magr + AXIS_W'(1)) : magr;
	assign bias_c = div_quo[BIAS_W-1:0] - {1'b0, center_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? ST_CAL : ST_CENTER;
				end
			end
			ST_CAL: state_d = done_q ? ST_CAL_DIV : ST_CENTER;
			ST_CAL_DIV: begin
				if (div_stat.done) begin
					state_d = ST_CENTER;
				end
			end
			ST_CENTER: state_d = ST_SHIFT;
			ST_SHIFT:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_SCL_GO;
			ST_SCL_GO: state_d = ST_SCL_WAIT;
			ST_SCL_WAIT: begin
				if (div_stat.done) begin
					if (last_ch) begin
						state_d = ST_FINISH;
					end else begin
						state_d = cmd_q ? ST_CAL : ST_CENTER;
					end
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready      = state_q == ST_IDLE;
		sel_cal       = state_q == ST_CAL;
		div_req.start = (sel_cal && done_q) || (state_q == ST_SCL_GO);
		div_req.steps = sel_cal ? STEPS_W'(QUO_W) : STEPS_W'(SCALE_SHIFT);
		out_load      = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);
	end

	// divider operands: average of the sums, or product / divisor for scaling
	always_comb begin
		if (sel_cal) begin
			div_rem = '0;
			div_num = new_sum;
			div_dvs = n_q;
		end else begin
			div_rem = prod_q[PW-1:SCALE_SHIFT];
			div_num = {prod_q[SCALE_SHIFT-1:0], {(QUO_W-SCALE_SHIFT){1'b0}}};
			div_dvs = den_q;
		end
	end

	jac_div #(
		.RW(RW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.rem_init (div_rem),
		.num_init (div_num),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			center_q   <= CENTER_RST;
			dz_q       <= DZ_RST;
			lim_q      <= LIM_RST;
			ncal_q     <= NCAL_RST;
			count_q    <= '0;
			ch_q       <= '0;
			cmd_q      <= 1'b0;
			done_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				bias_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_addr)
					REG_CENTER:   center_q <= cfg_wdata[CENTER_W-1:0];
					REG_DEADZONE: dz_q     <= cfg_wdata[DZ_W-1:0];
					REG_LIMIT:    lim_q    <= cfg_wdata[LIM_W-1:0];
					REG_NCAL:     ncal_q   <= cfg_wdata[NCAL_W-1:0];
				endcase
			end

			if (accept) begin
				ch_q   <= '0;
				cmd_q  <= s_tuser;
				done_q <= s_tuser && complete;
				if (s_tuser) begin
					count_q <= complete ? '0 : cnt_next;
				end
			end

			if (sel_cal) begin
				sum_q[ch_q] <= done_q ? '0 : new_sum;
			end

			if (state_q == ST_CAL_DIV && div_stat.done) begin
				bias_q[ch_q] <= bias_c;
			end

			if (state_q == ST_SCL_WAIT && div_stat.done) begin
				ch_q <= last_ch ? '0 : ch_q + CW'(1);
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				samp_q[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
			end
			// scaling divisor and sample count, held at least 1
			den_q <= (den_full[BIAS_W-1] || den_full == '0) ?
				DIV_W'(1) : den_full[DIV_W-1:0];
			n_q   <= {{(DIV_W-NCAL_W){1'b0}}, ncal_eff};
		end

		if (state_q == ST_CENTER) begin
			x_q <= x_c;
		end

		// move toward zero by the deadzone, zero inside it
		if (state_q == ST_SHIFT) begin
			neg_q <= x_q[XW-1];
			m_q   <= (mag_c[MW-1:0] < dz_ext) ? '0 : mag_c[MW-1:0] - dz_ext;
		end

		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
		end

		if (state_q == ST_SCL_WAIT && div_stat.done) begin
			res_q[ch_q] <= res_c;
		end

		if (out_load) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				m_tdata_q[i*AXIS_W +: AXIS_W] <= res_q[i];
			end
			m_tuser_q <= done_q;
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tvalid = m_tvalid_q;

endmodule

[tb/axis_result_checker.sv]
module axis_result_checker
	import jac_pkg::*;
(
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic [((NUM_CHANNELS_DEF*SAMPLE_BITS_DEF+7)/8)*8-1:0]   s_tdata,
	input  logic                                                    s_tuser,
	input  logic                                                    s_tvalid,
	input  logic                                                    s_tready,
	input  logic [((NUM_CHANNELS_DEF*AXIS_W+7)/8)*8-1:0]            m_tdata,
	input  logic                                                    m_tuser,
	input  logic                                                    m_tvalid,
	input  logic                                                    m_tready,
	input  logic                                                    cfg_we,
	input  logic [CFG_AW-1:0]                                       cfg_addr,
	input  logic [CFG_W-1:0]                                        cfg_wdata,
	output int                                                      errors,
	output int                                                      pending,
	output int                                                      scans_seen,
	output int                                                      cal_completions
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = NUM_CHANNELS_DEF;
	localparam int SB  = SAMPLE_BITS_DEF;

	typedef struct packed {
		logic                       done;
		logic [NCH-1:0][AXIS_W-1:0] axis;
	} axes_t;

	int unsigned center_lvl;
	int unsigned dz_width;
	int unsigned out_limit;
	int unsigned cal_target;

	logic signed [BIAS_W-1:0] ch_bias [NCH];
	logic [SUM_W-1:0]         cal_sum [NCH];
	logic [NCAL_W-1:0]        cal_count;

	axes_t expected_axes [$];
	int    results_seen;

	// deadzone, rescale toward full scale, then clip to +/- limit
	function automatic logic [AXIS_W-1:0] shape_axis(int x);
		int     dz;
		int     lim;
		int     den;
		longint y;
		dz  = int'(dz_width);
		lim = int'(out_limit);
		if (x < dz && x > -dz)
			return '0;
		if (x > 0)
			x -= dz;
		else
			x += dz;
		den = int'(center_lvl) - 1 - dz;
		if (den < 1)
			den = 1;
		y = (longint'(x) * longint'(lim)) / longint'(den);
		if (y > lim)
			y = lim;
		else if (y < -lim)
			y = -lim;
		return y[AXIS_W-1:0];
	endfunction

	function automatic axes_t predict_axes(logic cal_scan,
		logic [((NCH*SB+7)/8)*8-1:0] data);
		axes_t        res;
		int unsigned  n;
		int           avg;
		logic [SB-1:0] samp [NCH];
		res = '0;
		for (int ch = 0; ch < NCH; ch++)
			samp[ch] = data[ch*SB +: SB];
		if (cal_scan) begin
			n = (cal_target == 0) ? 1 : cal_target;
			for (int ch = 0; ch < NCH; ch++)
				cal_sum[ch] = cal_sum[ch] + SUM_W'(samp[ch]);
			cal_count = cal_count + 1'b1;
			// a lowered target completes as soon as the count reaches it
			if (cal_count >= n || cal_count == 0) begin
				for (int ch = 0; ch < NCH; ch++) begin
					avg = int'(cal_sum[ch]) / int'(n);
					ch_bias[ch] = BIAS_W'(avg - int'(center_lvl));
					cal_sum[ch] = '0;
				end
				cal_count = '0;
				res.done = 1'b1;
				cal_completions++;
			end
		end
		// the completing scan already sees the new biases
		for (int ch = 0; ch < NCH; ch++)
			res.axis[ch] = shape_axis(int'(samp[ch]) - int'(center_lvl) - int'(ch_bias[ch]));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		axes_t got;
		axes_t want;
		if (!arst_n) begin
			center_lvl      = CENTER_RST;
			dz_width        = DZ_RST;
			out_limit       = LIM_RST;
			cal_target      = NCAL_RST;
			cal_count       = '0;
			for (int ch = 0; ch < NCH; ch++) begin
				ch_bias[ch] = '0;
				cal_sum[ch] = '0;
			end
			expected_axes.delete();
			errors          = 0;
			pending         = 0;
			scans_seen      = 0;
			cal_completions = 0;
			results_seen    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_CENTER:   center_lvl = cfg_wdata[CENTER_W-1:0];
					REG_DEADZONE: dz_width   = cfg_wdata[DZ_W-1:0];
					REG_LIMIT:    out_limit  = cfg_wdata[LIM_W-1:0];
					REG_NCAL:     cal_target = cfg_wdata[NCAL_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.done = m_tuser;
				for (int ch = 0; ch < NCH; ch++)
					got.axis[ch] = m_tdata[ch*AXIS_W +: AXIS_W];
				if (expected_axes.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("result beat %0d arrived with no scan outstanding", results_seen);
				end else begin
					want = expected_axes.pop_front();
					for (int ch = 0; ch < NCH; ch++) begin
						if (got.axis[ch] !== want.axis[ch]) begin
							errors++;
							if (errors <= 10)
								$display("result %0d axis %0d: expected %0d, got %0d",
									results_seen, ch, $signed(want.axis[ch]),
									$signed(got.axis[ch]));
						end
					end
					if (got.done !== want.done) begin
						errors++;
						if (errors <= 10)
							$display("result %0d calibration flag: expected %0b, got %0b",
								results_seen, want.done, got.done);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				scans_seen++;
				expected_axes.push_back(predict_axes(s_tuser, s_tdata));
			end
			pending = expected_axes.size();
		end
	end

endmodule

[tb/tb_joystick_axis_conditioner.sv]
module tb_joystick_axis_conditioner;
	timeunit 1ns;
	timeprecision 1ps;
	import jac_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int SB           = SAMPLE_BITS_DEF;
	localparam int SDATA_W      = ((NCH*SB+7)/8)*8;
	localparam int MDATA_W      = ((NCH*AXIS_W+7)/8)*8;
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int SETTLE       = 300;
	localparam logic CMD_SCAN   = 1'b0;
	localparam logic CMD_CAL    = 1'b1;

	typedef logic [NCH-1:0][SB-1:0] scan_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic [SDATA_W-1:0] s_tdata   = '0;
	logic               s_tuser   = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [MDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [CFG_AW-1:0]  cfg_addr  = REG_CENTER;
	logic [CFG_W-1:0]   cfg_wdata = '0;

	int errors;
	int pending;
	int scans_seen;
	int cal_completions;

	int cycle_count   = 0;
	int burst_left    = 0;
	int scans_sent    = 0;
	int settings_used = 0;
	int cur_center    = CENTER_RST;
	int cur_dz        = DZ_RST;
	int cur_ncal      = NCAL_RST;

	joystick_axis_conditioner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	axis_result_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.errors          (errors),
		.pending         (pending),
		.scans_seen      (scans_seen),
		.cal_completions (cal_completions)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver back-pressure: a new mode is drawn each time rx_timer runs out
	int   rx_mode  = 0;
	int   rx_timer = 0;
	int   rx_hold  = 0;
	logic rx_level = 1'b1;

	always @(negedge clk) begin
		if (rx_timer == 0) begin
			rx_mode  = $urandom_range(0, 3);
			rx_timer = 256;
		end
		rx_timer--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: begin
				// long stretches of stall and accept
				if (rx_hold == 0) begin
					rx_level = ~rx_level;
					rx_hold  = $urandom_range(1, 60);
				end
				rx_hold--;
				m_tready <= rx_level;
			end
		endcase
	end

	task automatic send_scan(input logic cmd, input scan_t smp);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				3:       gap = $urandom_range(20, 120);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= SDATA_W'(smp);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scans_sent++;
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= CFG_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic configure(input int centre, input int dz, input int lim, input int ncal);
		drain();
		write_reg(REG_CENTER, centre);
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_LIMIT, lim);
		write_reg(REG_NCAL, ncal);
		cur_center = centre;
		cur_dz     = dz;
		cur_ncal   = ncal;
		settings_used++;
	endtask

	function automatic logic [SB-1:0] near_level(input int level, input int spread);
		int v;
		v = level + int'($urandom_range(0, 2*spread)) - spread;
		if (v < 0)
			v = 0;
		else if (v > 4095)
			v = 4095;
		return SB'(v);
	endfunction

	function automatic scan_t random_scan();
		scan_t smp;
		for (int ch = 0; ch < NCH; ch++) begin
			case ($urandom_range(0, 5))
				0:       smp[ch] = SB'($urandom_range(0, 4095));
				1:       smp[ch] = $urandom_range(0, 1) ? '1 : '0;
				default: smp[ch] = near_level(cur_center, cur_dz + 400);
			endcase
		end
		return smp;
	endfunction

	// calibration scans around a per-channel offset, with normal scans mixed in
	task automatic calib_run(input int len);
		int    offs [NCH];
		scan_t smp;
		for (int ch = 0; ch < NCH; ch++)
			offs[ch] = int'($urandom_range(0, 600)) - 300;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_scan(CMD_SCAN, random_scan());
			for (int ch = 0; ch < NCH; ch++)
				smp[ch] = near_level(cur_center + offs[ch], 8);
			send_scan(CMD_CAL, smp);
		end
	endtask

	initial begin
		int phase_end;
		int run_len;
		bit paused;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes and deadzone edges under reset settings
		send_scan(CMD_SCAN, {4{12'd0}});
		send_scan(CMD_SCAN, {4{12'd4095}});
		send_scan(CMD_SCAN, {4{12'd2048}});
		send_scan(CMD_SCAN, {12'd1947, 12'd2149, 12'd1948, 12'd2148});
		send_scan(CMD_SCAN, {12'd1949, 12'd2147, 12'h555, 12'hAAA});

		// two-scan calibration, then a plain scan on the new biases
		configure(2048, 100, 32767, 2);
		send_scan(CMD_CAL, {12'd2200, 12'd1900, 12'd2100, 12'd2000});
		send_scan(CMD_CAL, {12'd2201, 12'd1901, 12'd2101, 12'd2001});
		send_scan(CMD_SCAN, {4{12'd2048}});

		// zero sample target behaves as one
		configure(2048, 100, 32767, 0);
		send_scan(CMD_CAL, {12'd1, 12'd2048, 12'd0, 12'd4095});
		send_scan(CMD_SCAN, {4{12'd2048}});

		// target lowered part-way, bias wraps
		configure(1, 100, 32767, 5);
		repeat (3) send_scan(CMD_CAL, {4{12'd4095}});
		configure(1, 100, 32767, 1);
		send_scan(CMD_CAL, {4{12'd4095}});
		send_scan(CMD_SCAN, {12'd4095, 12'd0, 12'd2048, 12'd1});

		// zero limit, then a divisor that falls below one
		configure(100, 2047, 0, 20);
		send_scan(CMD_SCAN, {12'd0, 12'd4095, 12'd100, 12'd3000});
		configure(100, 99, 32767, 20);
		send_scan(CMD_SCAN, {12'd0, 12'd4095, 12'd199, 12'd1});
		send_scan(CMD_SCAN, {12'd200, 12'd0, 12'd4095, 12'd2});

		// random phases, the first four at extreme settings
		paused = 1'b0;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: configure(4095, 0, 32767, 1);
				1: configure(1, 0, 1, 1023);
				2: configure(0, 2047, 0, 0);
				3: configure(2048, 2047, 32767, 7);
				default: configure($urandom_range(1500, 2600), $urandom_range(0, 300),
					($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 32767),
					$urandom_range(1, 24));
			endcase
			phase_end = scans_sent + 200;
			while (scans_sent < phase_end) begin
				if (ph == 5 && !paused && scans_sent >= phase_end - 100) begin
					drain();
					paused = 1'b1;
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: send_scan(CMD_SCAN, random_scan());
					6, 7, 8: begin
						run_len = (cur_ncal >= 1 && cur_ncal <= 40) ? cur_ncal
							: $urandom_range(1, 40);
						calib_run(run_len);
					end
					default: begin
						// broken run or noise with any command
						if ($urandom_range(0, 1))
							calib_run($urandom_range(1, 3));
						else
							send_scan(1'($urandom_range(0, 1)), scan_t'({$urandom, $urandom}));
					end
				endcase
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("covered %0d scans over %0d register settings", scans_seen, settings_used + 1);
		$display("%0d calibrations completed, %0d check errors", cal_completions, errors);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
